// File: rtl/qvr_pkg.sv
// Package for the quaternion vector rotator: word types and defaults.
package qvr_pkg;

  localparam int QUAT_FRAC_BITS_DEF = 14;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] vec_x;
    logic signed [15:0] vec_y;
    logic signed [15:0] vec_z;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
    logic               clipped;
  } out_word_t;

endpackage

// File: rtl/quaternion_vector_rotate.sv
// Quaternion vector rotator: five-stage pipeline computing vec(q * (0,v) * conj(q)).
//
// Each input word carries a quaternion in signed fixed point with QUAT_FRAC_BITS
// fraction bits and an integer 3-vector; each output word is the rotated vector,
// rounded to nearest (halves toward plus infinity), saturated to 16 bits, with
// clipped set if any component saturated. The conjugate is used as the inverse,
// so a non-unit quaternion scales the result by |q|^2. The pipeline takes one
// word per clock unless all stages are full and out_ready is low, and holds
// five words in flight. Stages are: first-product multipliers (16x16), the
// first Hamilton sums, second-product multipliers (34x16), the second Hamilton
// sums, and round/saturate into the output register. Each stage has its own
// valid bit and advances when the stage after it is empty or advancing, so
// bubbles close up and in_ready stays high while a result waits, as long as
// an empty stage remains.
module quaternion_vector_rotate #(
  parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  qvr_pkg::in_word_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output qvr_pkg::out_word_t out_data
);

  localparam int SHIFT = 2 * QUAT_FRAC_BITS;
  localparam int SUM_W = (SHIFT + 2 > 52) ? SHIFT + 2 : 52;
  localparam logic signed [SUM_W-1:0] HALF = {{(SUM_W-1){1'b0}}, 1'b1} << (SHIFT - 1);
  localparam logic signed [SUM_W-1:0] MAXV = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] MINV = -SUM_W'(32768);

  // stage enables and valid bits
  logic en1, en2, en3, en4, en5;
  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  assign en5      = !v5_r || out_ready;
  assign en4      = !v4_r || en5;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  // stage 1: first products
  logic signed [31:0] wvx_r, wvy_r, wvz_r;
  logic signed [31:0] xvx_r, yvy_r, zvz_r;
  logic signed [31:0] yvz_r, zvy_r, zvx_r, xvz_r, xvy_r, yvx_r;
  logic signed [15:0] w1_r, x1_r, y1_r, z1_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      wvx_r <= in_data.quat_w * in_data.vec_x;
      wvy_r <= in_data.quat_w * in_data.vec_y;
      wvz_r <= in_data.quat_w * in_data.vec_z;
      xvx_r <= in_data.quat_x * in_data.vec_x;
      yvy_r <= in_data.quat_y * in_data.vec_y;
      zvz_r <= in_data.quat_z * in_data.vec_z;
      yvz_r <= in_data.quat_y * in_data.vec_z;
      zvy_r <= in_data.quat_z * in_data.vec_y;
      zvx_r <= in_data.quat_z * in_data.vec_x;
      xvz_r <= in_data.quat_x * in_data.vec_z;
      xvy_r <= in_data.quat_x * in_data.vec_y;
      yvx_r <= in_data.quat_y * in_data.vec_x;
      w1_r  <= in_data.quat_w;
      x1_r  <= in_data.quat_x;
      y1_r  <= in_data.quat_y;
      z1_r  <= in_data.quat_z;
    end
  end

  // stage 2: p = q * (0,v)
  logic signed [33:0] pw_r, px_r, py_r, pz_r;
  logic signed [15:0] w2_r, x2_r, y2_r, z2_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      pw_r <= -(34'(xvx_r) + 34'(yvy_r) + 34'(zvz_r));
      px_r <= 34'(wvx_r) + 34'(yvz_r) - 34'(zvy_r);
      py_r <= 34'(wvy_r) + 34'(zvx_r) - 34'(xvz_r);
      pz_r <= 34'(wvz_r) + 34'(xvy_r) - 34'(yvx_r);
      w2_r <= w1_r;
      x2_r <= x1_r;
      y2_r <= y1_r;
      z2_r <= z1_r;
    end
  end

  // stage 3: second products
  logic signed [49:0] pwx_r, pwy_r, pwz_r;
  logic signed [49:0] wpx_r, wpy_r, wpz_r;
  logic signed [49:0] pyz_r, pzy_r, pzx_r, pxz_r, pxy_r, pyx_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      pwx_r <= pw_r * x2_r;
      pwy_r <= pw_r * y2_r;
      pwz_r <= pw_r * z2_r;
      wpx_r <= px_r * w2_r;
      wpy_r <= py_r * w2_r;
      wpz_r <= pz_r * w2_r;
      pyz_r <= py_r * z2_r;
      pzy_r <= pz_r * y2_r;
      pzx_r <= pz_r * x2_r;
      pxz_r <= px_r * z2_r;
      pxy_r <= px_r * y2_r;
      pyx_r <= py_r * x2_r;
    end
  end

  // stage 4: vector part of p * conj(q)
  logic signed [SUM_W-1:0] r_r [3];

  always_ff @(posedge clk) begin
    if (en4) begin
      r_r[0] <= SUM_W'(wpx_r) - SUM_W'(pwx_r) - SUM_W'(pyz_r) + SUM_W'(pzy_r);
      r_r[1] <= SUM_W'(wpy_r) - SUM_W'(pwy_r) - SUM_W'(pzx_r) + SUM_W'(pxz_r);
      r_r[2] <= SUM_W'(wpz_r) - SUM_W'(pwz_r) - SUM_W'(pxy_r) + SUM_W'(pyx_r);
    end
  end

  // stage 5: round, scale, saturate
  logic signed [SUM_W-1:0] rnd     [3];
  logic signed [SUM_W-1:0] scaled  [3];
  logic signed [15:0]      sat_val [3];
  logic [2:0]              sat_hit;
  qvr_pkg::out_word_t      out_nxt;
  qvr_pkg::out_word_t      out_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rnd[k]    = r_r[k] + HALF;
      scaled[k] = rnd[k] >>> SHIFT;
      if (scaled[k] > MAXV) begin
        sat_val[k] = 16'sh7fff;
        sat_hit[k] = 1'b1;
      end else if (scaled[k] < MINV) begin
        sat_val[k] = -16'sh8000;
        sat_hit[k] = 1'b1;
      end else begin
        sat_val[k] = scaled[k][15:0];
        sat_hit[k] = 1'b0;
      end
    end
    out_nxt.rot_x   = sat_val[0];
    out_nxt.rot_y   = sat_val[1];
    out_nxt.rot_z   = sat_val[2];
    out_nxt.clipped = |sat_hit;
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = v5_r;
  assign out_data  = out_r;

endmodule

// File: verif/tb_quaternion_vector_rotate.sv
// Testbench for quaternion_vector_rotate: directed and random words checked against a predictor.
`timescale 1ns / 1ps

module tb_quaternion_vector_rotate;

  localparam int FRAC       = qvr_pkg::QUAT_FRAC_BITS_DEF;
  localparam int N_RANDOM   = 1450;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_OFF   = 150;

  class rotate_checker;
    qvr_pkg::out_word_t rot_queue[$];
    int n_words;
    int n_clipped;
    int n_mismatch;
    int n_orphan;

    function longint scale_round(longint acc);
      return (acc + (longint'(1) <<< (2 * FRAC - 1))) >>> (2 * FRAC);
    endfunction

    function qvr_pkg::out_word_t predict_rotation(qvr_pkg::in_word_t w);
      longint qw, qx, qy, qz, vx, vy, vz;
      longint pw, px, py, pz;
      longint r[3];
      logic signed [15:0] res[3];
      longint s;
      bit clip;
      qvr_pkg::out_word_t o;
      qw = w.quat_w; qx = w.quat_x; qy = w.quat_y; qz = w.quat_z;
      vx = w.vec_x;  vy = w.vec_y;  vz = w.vec_z;
      pw = -(qx * vx + qy * vy + qz * vz);
      px = qw * vx + qy * vz - qz * vy;
      py = qw * vy + qz * vx - qx * vz;
      pz = qw * vz + qx * vy - qy * vx;
      r[0] = -pw * qx + qw * px - (py * qz - pz * qy);
      r[1] = -pw * qy + qw * py - (pz * qx - px * qz);
      r[2] = -pw * qz + qw * pz - (px * qy - py * qx);
      clip = 1'b0;
      for (int k = 0; k < 3; k++) begin
        s = scale_round(r[k]);
        if (s > 32767) begin
          s = 32767;
          clip = 1'b1;
        end else if (s < -32768) begin
          s = -32768;
          clip = 1'b1;
        end
        res[k] = 16'(s);
      end
      o.rot_x   = res[0];
      o.rot_y   = res[1];
      o.rot_z   = res[2];
      o.clipped = clip;
      return o;
    endfunction

    function void note_input(qvr_pkg::in_word_t w);
      rot_queue.push_back(predict_rotation(w));
    endfunction

    function void check_result(qvr_pkg::out_word_t got);
      qvr_pkg::out_word_t want;
      if (rot_queue.size() == 0) begin
        n_orphan++;
        if (n_orphan + n_mismatch <= 10)
          $display("unexpected word: x=%0d y=%0d z=%0d clip=%0b",
                   got.rot_x, got.rot_y, got.rot_z, got.clipped);
        return;
      end
      want = rot_queue.pop_front();
      n_words++;
      if (want.clipped) n_clipped++;
      if (got.rot_x !== want.rot_x || got.rot_y !== want.rot_y ||
          got.rot_z !== want.rot_z || got.clipped !== want.clipped) begin
        n_mismatch++;
        if (n_orphan + n_mismatch <= 10)
          $display({"mismatch on word %0d: want x=%0d y=%0d z=%0d clip=%0b, ",
                    "got x=%0d y=%0d z=%0d clip=%0b"},
                   n_words, want.rot_x, want.rot_y, want.rot_z, want.clipped,
                   got.rot_x, got.rot_y, got.rot_z, got.clipped);
      end
    endfunction

    function int failures();
      return n_mismatch + n_orphan + rot_queue.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  qvr_pkg::in_word_t  in_data;
  logic               out_valid;
  logic               out_ready;
  qvr_pkg::out_word_t out_data;

  rotate_checker rc = new();
  int idle_cycles = 0;
  int n_directed = 0;

  quaternion_vector_rotate dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) rc.note_input(in_data);
      if (out_valid && out_ready) rc.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic qvr_pkg::in_word_t pack_word(int qw, int qx, int qy, int qz,
                                                  int vx, int vy, int vz);
    qvr_pkg::in_word_t w;
    w.quat_w = 16'(qw); w.quat_x = 16'(qx); w.quat_y = 16'(qy); w.quat_z = 16'(qz);
    w.vec_x  = 16'(vx); w.vec_y  = 16'(vy); w.vec_z  = 16'(vz);
    return w;
  endfunction

  function automatic int pick_gap(int idx);
    int r;
    r = $urandom_range(0, 99);
    if ((idx / 40) % 4 == 3) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic qvr_pkg::in_word_t random_word();
    qvr_pkg::in_word_t w;
    int r;
    int qv[4];
    int vv[3];
    real a[4];
    real mag;
    r = $urandom_range(0, 99);
    for (int k = 0; k < 3; k++) vv[k] = $urandom_range(0, 65535) - 32768;
    if (r < 35) begin
      for (int k = 0; k < 4; k++) qv[k] = $urandom_range(0, 65535) - 32768;
    end else if (r < 80) begin
      mag = 0.0;
      for (int k = 0; k < 4; k++) begin
        a[k] = real'($urandom_range(0, 65534)) - 32767.0;
        mag += a[k] * a[k];
      end
      mag = $sqrt(mag);
      for (int k = 0; k < 4; k++)
        qv[k] = (mag < 1.0) ? ((k == 0) ? 16384 : 0) : $rtoi(a[k] / mag * 16384.0);
      if ($urandom_range(0, 1) == 0)
        for (int k = 0; k < 3; k++) vv[k] = $urandom_range(0, 2047) - 1024;
    end else if (r < 92) begin
      for (int k = 0; k < 4; k++) begin
        case ($urandom_range(0, 7))
          0: qv[k] = 0;
          1: qv[k] = 16384;
          2: qv[k] = -16384;
          3: qv[k] = 11585;
          4: qv[k] = -11585;
          5: qv[k] = 32767;
          6: qv[k] = -32768;
          default: qv[k] = 8192;
        endcase
      end
    end else begin
      qv[0] = ($urandom_range(0, 1) == 0) ? 8192 : 0;
      for (int k = 1; k < 4; k++) qv[k] = 0;
      for (int k = 0; k < 3; k++) vv[k] = $urandom_range(0, 15) - 8;
    end
    w = pack_word(qv[0], qv[1], qv[2], qv[3], vv[0], vv[1], vv[2]);
    return w;
  endfunction

  task automatic send_word(qvr_pkg::in_word_t w, int gap);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  initial begin
    int len;
    bit level;
    bit held_first;
    bit held_second;
    held_first  = 1'b0;
    held_second = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!held_first && rc.n_words >= 400 || !held_second && rc.n_words >= 1000) begin
        if (rc.n_words >= 1000) held_second = 1'b1;
        held_first = 1'b1;
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (HOLD_OFF - 1) @(negedge clk);
      end
      len = $urandom_range(0, 99);
      if (len < 60) begin
        level = 1'b1;
        len = $urandom_range(1, 16);
      end else begin
        level = 1'b0;
        if (len < 90) len = $urandom_range(1, 3);
        else if (len < 98) len = $urandom_range(4, 15);
        else len = $urandom_range(20, 50);
      end
      @(negedge clk);
      out_ready <= level;
      repeat (len - 1) @(negedge clk);
    end
  end

  initial begin
    qvr_pkg::in_word_t directed[$];
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    directed.push_back(pack_word(16384, 0, 0, 0, 100, -200, 300));
    directed.push_back(pack_word(0, 0, 0, 0, 32767, -32768, 1000));
    directed.push_back(pack_word(-16384, 0, 0, 0, -32768, 32767, -1));
    directed.push_back(pack_word(11585, 0, 0, 11585, 1000, 0, 0));
    directed.push_back(pack_word(0, 16384, 0, 0, 1, 2, 3));
    directed.push_back(pack_word(0, 0, 16384, 0, 32767, 32767, 32767));
    directed.push_back(pack_word(0, 0, 0, 16384, -32768, -32768, -32768));
    directed.push_back(pack_word(32767, 32767, 32767, 32767, 32767, 32767, 32767));
    directed.push_back(pack_word(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
    directed.push_back(pack_word(32767, -32768, 32767, -32768, -32768, 32767, -32768));
    directed.push_back(pack_word(32767, 0, 0, 0, 20000, -20000, 100));
    directed.push_back(pack_word(8192, 0, 0, 0, 2, -2, 3));
    directed.push_back(pack_word(8192, 0, 0, 0, -3, 1, -1));
    directed.push_back(pack_word(1, 1, 1, 1, 32767, 32767, 32767));
    directed.push_back(pack_word(-1, -1, -1, -1, -32768, -32768, -32768));
    directed.push_back(pack_word(8192, 8192, 8192, 8192, 10000, 20000, -30000));
    directed.push_back(pack_word(12345, -2345, 3456, -4567, 0, 0, 0));
    directed.push_back(pack_word(0, 0, 0, 0, 0, 0, 0));
    directed.push_back(pack_word(-11585, 11585, 0, 0, -1, 0, 32767));
    n_directed = directed.size();

    foreach (directed[i]) send_word(directed[i], pick_gap(i));
    for (int i = 0; i < N_RANDOM; i++) send_word(random_word(), pick_gap(i));
    @(negedge clk);
    in_valid <= 1'b0;

    while (rc.rot_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Rotated %0d words (%0d directed, %0d random); %0d predicted with saturation.",
             rc.n_words, n_directed, N_RANDOM, rc.n_clipped);
    $display("Mismatches %0d, unexpected words %0d, words never returned %0d.",
             rc.n_mismatch, rc.n_orphan, rc.rot_queue.size());
    if (rc.failures() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: quaternion_vector_rotate.f
rtl/qvr_pkg.sv
rtl/quaternion_vector_rotate.sv
verif/tb_quaternion_vector_rotate.sv
